/* hw/rtl/mmes_pkg.sv */
// ----------------------------------------------------------------------------
// mmes_pkg
// Shared types and constants for the mean/median of even samples core.
// ----------------------------------------------------------------------------
package mmes_pkg;

  localparam int unsigned DefCount      = 15;
  localparam int unsigned DefSampleBits = 16;

  localparam int unsigned SumW    = 22;
  localparam int unsigned CntW    = 7;
  localparam int unsigned MeanW   = 19;
  localparam int unsigned MedW    = 16;
  localparam int unsigned DvdW    = SumW + 4;
  localparam int unsigned OutDataW = ((CntW + MeanW + MedW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    STAT_REJECT = 2'd0,
    STAT_STORED = 2'd1,
    STAT_DONE   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_GRAB,
    S_SWEEP,
    S_DRAIN,
    S_JUDGE,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [CntW-1:0]      cnt;
    logic [MeanW-1:0]     mean;
    logic [MedW-1:0]      med;
  } result_t;

endpackage

/* hw/rtl/mmes_ram.sv */
// ----------------------------------------------------------------------------
// mmes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmes_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 15,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/mean_median_of_even_samples_core.sv */
// ----------------------------------------------------------------------------
// mean_median_of_even_samples_core
// Collects COUNT positive even samples, then reports mean (Q4) and 2x median.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: sample
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: stored_count,
//                                            mean_q4, median_x2
//
// A rejected or stored sample leaves the core in idle, ready for the next one. The
// sample that completes a set holds off input until its result is written: a rank
// count of every entry against every entry through the store's single read port
// and two compares, then one reciprocal multiply for the divide by COUNT.
// Reset clears count, sum and control; store contents are not cleared.
// Two-deep output buffer; input is taken in idle while a result slot is free.
// ----------------------------------------------------------------------------
module mean_median_of_even_samples_core
  import mmes_pkg::*;
#(
  parameter int unsigned COUNT       = DefCount,
  parameter int unsigned SAMPLE_BITS = DefSampleBits,
  localparam int unsigned InDataW    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // stored_count, mean_q4, median_x2
  output logic [1:0]          m_axis_tuser    // status
);

  localparam int unsigned AW = (COUNT > 1) ? $clog2(COUNT) : 1;
  localparam logic [CntW-1:0] CountC = CntW'(COUNT);
  localparam logic [CntW-1:0] TgtLo  = CntW'((COUNT - 1) / 2);
  localparam logic [CntW-1:0] TgtHi  = CntW'(COUNT / 2);
  localparam logic [AW-1:0]   LastIx = AW'(COUNT - 1);

  // floor(x / COUNT) = (x * Recip) >> RecipSh, exact for any DvdW-bit x
  localparam int unsigned   RecipSh   = DvdW + $clog2(COUNT);
  localparam logic [63:0]   RecipFull = ((64'd1 << RecipSh) + 64'(COUNT) - 64'd1) /
                                        64'(COUNT);
  localparam logic [DvdW:0] Recip     = RecipFull[DvdW:0];
  localparam int unsigned   ProdW     = 2 * DvdW + 1;

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] sample;
  logic                   s_acc, keep;
  logic [CntW-1:0]        held_q, held_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic [AW-1:0]          i_q, i_d, j_q, j_d;
  logic [SAMPLE_BITS-1:0] cand_q, cand_d, lo_q, lo_d, hi_q, hi_d;
  logic [CntW-1:0]        lt_q, lt_d, le_q, le_d;
  logic                   rvld_q, rvld_d;
  logic [DvdW-1:0]        dvd_q, dvd_d;
  logic [ProdW-1:0]       prod;
  logic [SAMPLE_BITS:0]   med_sum;

  logic                   ram_we;
  logic [AW-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  result_t res_d, pend_q, out_q;
  logic    res_we, pend_v_q, out_v_q, out_free, room;

  assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign keep     = !sample[SAMPLE_BITS-1] && (sample != '0) && !sample[0];
  assign out_free = !out_v_q || m_axis_tready;
  assign room     = !pend_v_q || out_free;
  assign s_axis_tready = (state_q == S_IDLE) && room;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign ram_we   = s_acc && keep;

  assign prod    = ProdW'(dvd_q) * ProdW'(Recip);
  assign med_sum = {1'b0, lo_q} + {1'b0, hi_q};

  mmes_ram #(
    .Width (SAMPLE_BITS),
    .Depth (COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (held_q[AW-1:0]),
    .wdata_i (sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    sum_d     = sum_q;
    i_d       = i_q;
    j_d       = j_q;
    cand_d    = cand_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    lt_d      = lt_q;
    le_d      = le_q;
    rvld_d    = 1'b0;
    dvd_d     = dvd_q;
    ram_raddr = i_q;
    res_we    = 1'b0;
    res_d     = '{status: STAT_REJECT, cnt: held_q, mean: '0, med: '0};

    if (rvld_q) begin
      if (ram_rdata < cand_q)  lt_d = lt_q + 1'b1;
      if (ram_rdata <= cand_q) le_d = le_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          if (!keep) begin
            res_we = 1'b1;
          end else begin
            held_d = held_q + 1'b1;
            sum_d  = sum_q + SumW'(sample);
            if (held_d == CountC) begin
              i_d     = '0;
              state_d = S_CAND;
            end else begin
              res_we       = 1'b1;
              res_d.status = STAT_STORED;
              res_d.cnt    = held_d;
            end
          end
        end
      end
      S_CAND: begin
        ram_raddr = i_q;
        state_d   = S_GRAB;
      end
      S_GRAB: begin
        cand_d  = ram_rdata;
        lt_d    = '0;
        le_d    = '0;
        j_d     = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        ram_raddr = j_q;
        rvld_d    = 1'b1;
        j_d       = j_q + 1'b1;
        if (j_q == LastIx) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_JUDGE;
      end
      S_JUDGE: begin
        if (lt_q <= TgtLo && TgtLo < le_q) lo_d = cand_q;
        if (lt_q <= TgtHi && TgtHi < le_q) hi_d = cand_q;
        i_d = i_q + 1'b1;
        if (i_q == LastIx) begin
          dvd_d   = {sum_q, 4'b0000};
          state_d = S_DIV;
        end else begin
          state_d = S_CAND;
        end
      end
      S_DIV: begin
        dvd_d   = DvdW'(prod[RecipSh +: MeanW]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (room) begin
          res_we  = 1'b1;
          res_d   = '{status: STAT_DONE, cnt: CountC, mean: dvd_q[MeanW-1:0],
                      med: MedW'(med_sum)};
          held_d  = '0;
          sum_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      held_q   <= '0;
      sum_q    <= '0;
      rvld_q   <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      sum_q   <= sum_d;
      rvld_q  <= rvld_d;
      if (out_free) begin
        out_v_q  <= pend_v_q || res_we;
        pend_v_q <= pend_v_q && res_we;
      end else if (res_we) begin
        pend_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    cand_q <= cand_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    dvd_q  <= dvd_d;
    if (out_free) begin
      out_q <= pend_v_q ? pend_q : res_d;
      if (res_we) pend_q <= res_d;
    end else if (res_we) begin
      pend_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OutDataW'({out_q.med, out_q.mean, out_q.cnt});

endmodule

/* hw/rtl/mmes_checker.sv */
// ----------------------------------------------------------------------------
// mmes_checker
// Port-level checks on the result stream of the core.
// ----------------------------------------------------------------------------
module mmes_checker
  import mmes_pkg::*;
#(
  parameter int unsigned COUNT = DefCount
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  logic [CntW-1:0]  cnt;
  logic [MeanW-1:0] mean;
  logic [MedW-1:0]  med;

  assign cnt  = m_axis_tdata[CntW-1:0];
  assign mean = m_axis_tdata[CntW+MeanW-1:CntW];
  assign med  = m_axis_tdata[CntW+MeanW+MedW-1:CntW+MeanW];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_done_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_DONE |-> cnt == CntW'(COUNT))
    else $error("completed set does not report COUNT samples");

  a_stored_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_STORED |->
      cnt != '0 && cnt < CntW'(COUNT))
    else $error("stored beat with out-of-range count");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != STAT_DONE |-> mean == '0 && med == '0)
    else $error("result fields set on a beat without a completed set");

endmodule

bind mean_median_of_even_samples_core mmes_checker #(
  .COUNT (COUNT)
) u_mmes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for mean_median_of_even_samples_core. Offers signed
// samples, some directed and the rest random, with random idling on both
// sides. Sets are mostly positive even values so that many sets complete.
// An in-line model tracks the set fill, the sum and the stored values, and
// predicts status, count, Q4 mean and doubled median for every beat. Each
// output beat is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import mmes_pkg::*;
();

  localparam int unsigned SetSize    = DefCount;
  localparam int unsigned SampleW    = DefSampleBits;
  localparam int unsigned RandItems  = 600;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned HoldCycles = 700;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [SampleW-1:0] smp;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  // model state
  logic [SampleW-1:0] set_values [SetSize];
  logic [CntW-1:0]    set_fill  = '0;
  logic [SumW-1:0]    set_total = '0;

  result_t     pending_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          hold_req       = 1'b0;

  stim_row_t directed_rows [22] = '{
    '{16'h0000, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}},
    '{16'h8000, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}},
    '{16'h7FFF, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}},
    '{16'hFFFE, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}},
    '{16'h0001, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}},
    '{16'h0002, 1'b1, '{STAT_STORED, 7'd1, 19'd0, 16'd0}},
    '{16'hFFFF, 1'b1, '{STAT_REJECT, 7'd1, 19'd0, 16'd0}},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b0, '0},
    '{16'h7FFE, 1'b1, '{STAT_DONE, 7'd15, 19'd489307, 16'd65532}},
    '{16'h7FFF, 1'b1, '{STAT_REJECT, 7'd0, 19'd0, 16'd0}}
  };

  mean_median_of_even_samples_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t absorb_sample(input logic [SampleW-1:0] smp);
    result_t            res;
    logic [SampleW-1:0] ordered [SetSize];
    logic [SampleW-1:0] key;
    logic [SumW+3:0]    scaled;
    int                 i;
    int                 j;
    res = '0;
    if (smp[SampleW-1] || smp == '0 || smp[0]) begin
      res.status = STAT_REJECT;
      res.cnt    = set_fill;
      return res;
    end
    set_values[set_fill] = smp;
    set_fill  = set_fill + 1'b1;
    set_total = set_total + SumW'(smp);
    if (set_fill == SetSize) begin
      ordered = set_values;
      for (i = 1; i < SetSize; i++) begin
        key = ordered[i];
        j   = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      scaled     = {set_total, 4'b0000};
      res.status = STAT_DONE;
      res.cnt    = CntW'(SetSize);
      res.mean   = MeanW'(scaled / SetSize);
      if (SetSize % 2 == 0) begin
        res.med = ordered[SetSize/2-1] + ordered[SetSize/2];
      end else begin
        res.med = ordered[SetSize/2] << 1;
      end
      set_fill  = '0;
      set_total = '0;
    end else begin
      res.status = STAT_STORED;
      res.cnt    = set_fill;
    end
    return res;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return SampleW'($urandom_range(1, 8) * 2);
    end else if (roll < 70) begin
      return SampleW'($urandom_range(1, 16383) * 2);
    end else if (roll < 78) begin
      return SampleW'(32766 - 2 * $urandom_range(0, 7));
    end else if (roll < 82) begin
      return '0;
    end else if (roll < 92) begin
      return {1'b1, 15'($urandom())};
    end
    return {1'b0, 14'($urandom()), 1'b1};
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SampleW-1:0] smp, input bit typed,
                             input result_t want);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = absorb_sample(smp);
    if (typed) predicted = want;
    pending_results = {pending_results, predicted};
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver ready, with a long hold-off on request
  initial begin : sink_ready
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_beat
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected beat, tdata", m_axis_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) flag_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[6:0] !== want.cnt) flag_mismatch("stored_count", m_axis_tdata[6:0], want.cnt);
        if (m_axis_tdata[25:7] !== want.mean) flag_mismatch("mean_q4", m_axis_tdata[25:7], want.mean);
        if (m_axis_tdata[41:26] !== want.med) flag_mismatch("median_x2", m_axis_tdata[41:26], want.med);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned send_pct [3] = '{11, 59, 0};
    int unsigned recv_pct [3] = '{59, 11, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = send_pct[0];
    recv_idle_pct = recv_pct[0];
    foreach (directed_rows[k]) begin
      send_sample(directed_rows[k].smp, directed_rows[k].typed, directed_rows[k].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (n = 0; n < RandItems / 3; n++) begin
        if (ph == 2 && n == 40) hold_req = 1'b1;
        send_sample(pick_sample(), 1'b0, '0);
      end
      // sender pauses until every result is back
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mmes_pkg.sv
hw/rtl/mmes_ram.sv
hw/rtl/mean_median_of_even_samples_core.sv
hw/rtl/mmes_checker.sv
verif/tb_top.sv
